/* rtl/core/mcs_pkg.sv */
// shared types and constants of the motion command sequencer
// no dependencies; imported by the core and the testbench
`default_nettype none

package mcs_pkg;

    localparam int MAX_COMMANDS = 32;
    localparam int CMD_ADDR_W   = $clog2(MAX_COMMANDS);
    localparam int CMD_CNT_W    = $clog2(MAX_COMMANDS + 1);
    localparam int ENTRY_W      = 30;

    // item kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_POLL   = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    // command types
    localparam logic [2:0] TYPE_TABLE  = 3'd0;
    localparam logic [2:0] TYPE_SCREW  = 3'd1;
    localparam logic [2:0] TYPE_BOTH   = 3'd2;
    localparam logic [2:0] TYPE_GRAB   = 3'd3;
    localparam logic [2:0] TYPE_LOOSEN = 3'd4;
    localparam logic [2:0] TYPE_OPEN   = 3'd5;

    // gripper codes
    localparam logic [1:0] GRIP_NONE = 2'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_SETTLE      = 2'd0;
    localparam logic [1:0] CFG_TABLE_GAIN  = 2'd1;
    localparam logic [1:0] CFG_SCREW_GAIN  = 2'd2;
    localparam int         CFG_DATA_W      = 24;

    localparam logic [15:0] SETTLE_RESET     = 16'd900;
    localparam logic [19:0] TABLE_GAIN_RESET = 20'd7646;
    localparam logic [23:0] SCREW_GAIN_RESET = 24'd2097152;

    localparam logic [12:0] TABLE_MAX_STEPS = 13'h1FFF;
    localparam logic [16:0] SCREW_MAX_MAG   = 17'h10000;

endpackage

`default_nettype wire

/* rtl/core/mcs_in_if.sv */
// request channel of the motion command sequencer
// depends on nothing but the handshake; payload is the command item
`default_nettype none

interface mcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  command_type;
    logic [15:0] table_angle_centideg;
    logic [10:0] screw_depth_tenth_mm;
    logic        table_at_target;
    logic        screw_at_target;
    logic [31:0] now_ms;

    modport source (
        output valid, kind, command_type, table_angle_centideg,
               screw_depth_tenth_mm, table_at_target, screw_at_target, now_ms,
        input  ready
    );
    modport sink (
        input  valid, kind, command_type, table_angle_centideg,
               screw_depth_tenth_mm, table_at_target, screw_at_target, now_ms,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/mcs_out_if.sv */
// result channel of the motion command sequencer
// depends on nothing but the handshake; payload is the status item
`default_nettype none

interface mcs_out_if;
    logic               valid;
    logic               ready;
    logic [12:0]        table_target_steps;
    logic               table_issue;
    logic signed [16:0] screw_target_steps;
    logic               screw_issue;
    logic [1:0]         gripper_command;
    logic               sequence_done;
    logic [5:0]         command_position;
    logic               load_rejected;

    modport source (
        output valid, table_target_steps, table_issue, screw_target_steps,
               screw_issue, gripper_command, sequence_done, command_position,
               load_rejected,
        input  ready
    );
    modport sink (
        input  valid, table_target_steps, table_issue, screw_target_steps,
               screw_issue, gripper_command, sequence_done, command_position,
               load_rejected,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/motion_command_sequencer_core.sv */
// motion command sequencer: command list in ram, poll-driven execution
// depends on mcs_pkg, mcs_in_if, mcs_out_if and mcs_ram
//
// usage:
//   i_cmd carries requests: append a command, clear the list, poll with
//   axis status and the millisecond time, or an idle status request.
//   o_res returns exactly one status item for every request.
//   i_cfg_we / i_cfg_idx / i_cfg_data write settle time (0), table gain (1)
//   and screw gain (2); write only while no request is in flight.
// flow:
//   append, clear and idle requests give their result the cycle after
//   acceptance. a poll that reaches a stored command goes through a ram
//   read, gain multiply, then saturation into the output register.
//   one request is in flight at a time: non-poll requests are taken one per
//   cycle while the receiver takes results; such a poll holds off new ones.
// reset:
//   synchronous, active low; clears the list, the position and the output
//   valid, and loads the default gains and settle time. the ram needs no
//   clearing since only entries below the count are ever read.
// stall:
//   a result waits in the output register; no new request is taken until it
//   leaves or leaves in the same cycle.
`default_nettype none

module motion_command_sequencer_core
    import mcs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mcs_in_if.sink                     i_cmd,
    mcs_out_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_settle;
    logic [19:0] r_table_gain;
    logic [23:0] r_screw_gain;

    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic [CMD_CNT_W-1:0] r_cur, n_cur;
    logic                 r_started, n_started;
    logic [31:0]          r_servo_start, n_servo_start;

    // poll operands latched at acceptance
    logic [31:0] r_now;
    logic        r_t_at;
    logic        r_s_at;

    // exec stage results
    logic [35:0] r_tprod;
    logic [34:0] r_sprod;
    logic        r_t_iss, r_s_iss;
    logic [1:0]  r_grip;

    // output register
    logic               r_out_valid;
    logic [12:0]        r_o_ttgt, n_o_ttgt;
    logic               r_o_tiss, n_o_tiss;
    logic signed [16:0] r_o_stgt, n_o_stgt;
    logic               r_o_siss, n_o_siss;
    logic [1:0]         r_o_grip, n_o_grip;
    logic               r_o_done, n_o_done;
    logic [5:0]         r_o_pos, n_o_pos;
    logic               r_o_rej, n_o_rej;

    logic out_free, accept, poll_busy, load_out;
    logic ram_we, ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [2:0]  e_type;
    logic [15:0] e_angle;
    logic [10:0] e_depth;
    logic        issue_now, is_grip, finished;
    logic [31:0] start_eff, elapsed;
    logic [19:0] t_steps;
    logic [18:0] s_mag_raw;
    logic [16:0] s_mag;

    assign out_free  = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign accept    = i_cmd.valid && i_cmd.ready;
    assign poll_busy = (i_cmd.kind == KIND_POLL) && (r_cur < r_count);
    assign ram_we    = accept && (i_cmd.kind == KIND_APPEND)
                       && (r_count < CMD_CNT_W'(MAX_COMMANDS));
    assign ram_re    = accept && poll_busy;
    assign load_out  = (accept && !poll_busy) || ((r_state == S_FINISH) && out_free);

    mcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COMMANDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[CMD_ADDR_W-1:0]),
        .i_wdata ({i_cmd.command_type, i_cmd.table_angle_centideg,
                   i_cmd.screw_depth_tenth_mm}),
        .i_re    (ram_re),
        .i_raddr (r_cur[CMD_ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // entry decode and completion check
    assign e_type    = ram_rdata[29:27];
    assign e_angle   = ram_rdata[26:11];
    assign e_depth   = ram_rdata[10:0];
    assign issue_now = !r_started;
    assign is_grip   = (e_type == TYPE_GRAB) || (e_type == TYPE_LOOSEN)
                       || (e_type == TYPE_OPEN);
    assign start_eff = (issue_now && is_grip) ? r_now : r_servo_start;
    assign elapsed   = r_now - start_eff;

    always_comb begin
        case (e_type) inside
            TYPE_TABLE:                        finished = !issue_now && r_t_at;
            TYPE_SCREW:                        finished = !issue_now && r_s_at;
            TYPE_BOTH:                         finished = !issue_now && r_t_at && r_s_at;
            TYPE_GRAB, TYPE_LOOSEN, TYPE_OPEN: finished = elapsed >= {16'd0, r_settle};
            default:                           finished = 1'b1;
        endcase
    end

    // saturation of the registered products
    assign t_steps   = r_tprod[35:16];
    assign s_mag_raw = r_sprod[34:16];
    assign s_mag     = (s_mag_raw > {2'd0, SCREW_MAX_MAG}) ? SCREW_MAX_MAG : s_mag_raw[16:0];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cur         = r_cur;
        n_started     = r_started;
        n_servo_start = r_servo_start;
        n_o_ttgt      = '0;
        n_o_tiss      = 1'b0;
        n_o_stgt      = '0;
        n_o_siss      = 1'b0;
        n_o_grip      = GRIP_NONE;
        n_o_done      = 1'b0;
        n_o_pos       = 6'(r_cur);
        n_o_rej       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.kind)
                        KIND_APPEND: begin
                            if (r_count >= CMD_CNT_W'(MAX_COMMANDS)) begin
                                n_o_rej = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            n_o_done = r_cur >= n_count;
                        end
                        KIND_CLEAR: begin
                            n_count   = '0;
                            n_cur     = '0;
                            n_started = 1'b0;
                            n_o_done  = 1'b1;
                            n_o_pos   = '0;
                        end
                        KIND_POLL: begin
                            if (poll_busy) begin
                                n_state = S_EXEC;
                            end else begin
                                n_o_done = 1'b1;
                            end
                        end
                        KIND_IDLE: begin
                            n_o_done = r_cur >= r_count;
                        end
                        default: begin
                            n_o_done = r_cur >= r_count;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_state   = S_FINISH;
                n_started = 1'b1;
                if (issue_now && is_grip) begin
                    n_servo_start = r_now;
                end
                if (finished) begin
                    n_cur     = r_cur + 1'b1;
                    n_started = 1'b0;
                end
            end
            S_FINISH: begin
                n_o_tiss = r_t_iss;
                n_o_siss = r_s_iss;
                n_o_grip = r_grip;
                if (r_t_iss) begin
                    n_o_ttgt = (t_steps > {7'd0, TABLE_MAX_STEPS}) ? TABLE_MAX_STEPS
                                                                    : t_steps[12:0];
                end
                if (r_s_iss) begin
                    n_o_stgt = signed'(17'(17'd0 - s_mag));
                end
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_cur         <= '0;
            r_started     <= 1'b0;
            r_servo_start <= '0;
            r_out_valid   <= 1'b0;
            r_settle      <= SETTLE_RESET;
            r_table_gain  <= TABLE_GAIN_RESET;
            r_screw_gain  <= SCREW_GAIN_RESET;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_cur         <= n_cur;
            r_started     <= n_started;
            r_servo_start <= n_servo_start;
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SETTLE:     r_settle     <= i_cfg_data[15:0];
                    CFG_TABLE_GAIN: r_table_gain <= i_cfg_data[19:0];
                    CFG_SCREW_GAIN: r_screw_gain <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= i_cmd.now_ms;
            r_t_at <= i_cmd.table_at_target;
            r_s_at <= i_cmd.screw_at_target;
        end
        if (r_state == S_EXEC) begin
            r_tprod <= {20'd0, e_angle} * {16'd0, r_table_gain};
            r_sprod <= {24'd0, e_depth} * {11'd0, r_screw_gain};
            r_t_iss <= issue_now && ((e_type == TYPE_TABLE) || (e_type == TYPE_BOTH));
            r_s_iss <= issue_now && ((e_type == TYPE_SCREW) || (e_type == TYPE_BOTH));
            r_grip  <= (issue_now && is_grip) ? 2'(e_type - 3'd2) : GRIP_NONE;
        end
        if (load_out) begin
            r_o_ttgt <= n_o_ttgt;
            r_o_tiss <= n_o_tiss;
            r_o_stgt <= n_o_stgt;
            r_o_siss <= n_o_siss;
            r_o_grip <= n_o_grip;
            r_o_done <= n_o_done;
            r_o_pos  <= n_o_pos;
            r_o_rej  <= n_o_rej;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.table_target_steps = r_o_ttgt;
    assign o_res.table_issue        = r_o_tiss;
    assign o_res.screw_target_steps = r_o_stgt;
    assign o_res.screw_issue        = r_o_siss;
    assign o_res.gripper_command    = r_o_grip;
    assign o_res.sequence_done      = r_o_done;
    assign o_res.command_position   = r_o_pos;
    assign o_res.load_rejected      = r_o_rej;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMD_CNT_W'(MAX_COMMANDS))
        else $error("command count beyond capacity");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_count)
        else $error("current command beyond count");

    a_poll_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == S_EXEC))
        else $error("store read without exec stage");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_rej) |-> (r_count == CMD_CNT_W'(MAX_COMMANDS)))
        else $error("append rejected while list not full");

    a_issue_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_o_tiss || r_o_siss) |-> (r_o_grip == GRIP_NONE))
        else $error("motion and gripper issued together");
`endif

endmodule

`default_nettype wire

/* rtl/core/mcs_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module mcs_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* verif/tb_motion_command_sequencer_core.sv */
`timescale 1ns / 1ps
// testbench of motion_command_sequencer_core: random bursts of requests, a stalling
// receiver and a status predictor checked field by field; depends on mcs_pkg and the
// request and result channel interfaces

module tb_motion_command_sequencer_core;
    import mcs_pkg::*;

    localparam logic [2:0] TYPE_SPARE_A   = 3'd6;
    localparam logic [2:0] TYPE_SPARE_B   = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  command_type;
        logic [15:0] angle;
        logic [10:0] depth;
        logic        table_at;
        logic        screw_at;
        logic [31:0] now_ms;
    } t_cmd_item;

    typedef struct packed {
        logic [12:0] table_target;
        logic        table_issue;
        logic [16:0] screw_target;
        logic        screw_issue;
        logic [1:0]  gripper;
        logic        done;
        logic [5:0]  position;
        logic        rejected;
    } t_status;

    typedef struct packed {
        logic [2:0]  ctype;
        logic [15:0] angle;
        logic [10:0] depth;
    } t_stored_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcs_in_if  cmd_bus ();
    mcs_out_if res_bus ();

    motion_command_sequencer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state and its copy of the registers
    t_stored_cmd cmd_list [MAX_COMMANDS];
    int          list_count;
    int          run_index;
    bit          run_started;
    logic [31:0] settle_start;
    logic [15:0] cfg_settle;
    logic [19:0] cfg_table_gain;
    logic [23:0] cfg_screw_gain;

    t_cmd_item   pending_requests [$];
    t_status     status_expected [$];
    int          error_count;
    int          items_sent;
    int          burst_left;
    int          gap_left;
    int          quiet_cycles;
    int          stall_mode;
    logic [31:0] stall_tick;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic t_status predict_status(t_cmd_item it);
        t_status     r;
        t_stored_cmd entry;
        logic [63:0] prod;
        logic [31:0] elapsed;
        bit          fresh;
        bit          finished;
        r = '0;
        case (it.kind)
            KIND_APPEND: begin
                if (list_count >= MAX_COMMANDS) begin
                    r.rejected = 1'b1;
                end else begin
                    cmd_list[list_count] = '{it.command_type, it.angle, it.depth};
                    list_count++;
                end
                r.done = (run_index >= list_count);
            end
            KIND_CLEAR: begin
                list_count  = 0;
                run_index   = 0;
                run_started = 1'b0;
                r.done      = 1'b1;
            end
            KIND_POLL: begin
                if (run_index >= list_count) begin
                    r.done = 1'b1;
                end else begin
                    entry = cmd_list[run_index];
                    fresh = !run_started;
                    if (fresh) begin
                        if (entry.ctype == TYPE_TABLE || entry.ctype == TYPE_BOTH) begin
                            prod = (64'(entry.angle) * 64'(cfg_table_gain)) >> 16;
                            r.table_target = (prod > 64'(TABLE_MAX_STEPS)) ?
                                             TABLE_MAX_STEPS : prod[12:0];
                            r.table_issue  = 1'b1;
                        end
                        if (entry.ctype == TYPE_SCREW || entry.ctype == TYPE_BOTH) begin
                            prod = (64'(entry.depth) * 64'(cfg_screw_gain)) >> 16;
                            if (prod > 64'(SCREW_MAX_MAG))
                                prod = 64'(SCREW_MAX_MAG);
                            r.screw_target = 17'(64'd0 - prod);
                            r.screw_issue  = 1'b1;
                        end
                        if (entry.ctype >= TYPE_GRAB && entry.ctype <= TYPE_OPEN) begin
                            r.gripper    = 2'(entry.ctype - 3'd2);
                            settle_start = it.now_ms;
                        end
                        run_started = 1'b1;
                    end
                    elapsed = it.now_ms - settle_start;
                    case (entry.ctype)
                        TYPE_TABLE:  finished = !fresh && it.table_at;
                        TYPE_SCREW:  finished = !fresh && it.screw_at;
                        TYPE_BOTH:   finished = !fresh && it.table_at && it.screw_at;
                        TYPE_GRAB, TYPE_LOOSEN, TYPE_OPEN:
                                     finished = (elapsed >= 32'(cfg_settle));
                        default:     finished = 1'b1;
                    endcase
                    if (finished) begin
                        run_index++;
                        run_started = 1'b0;
                    end
                end
            end
            default: begin
                r.done = (run_index >= list_count);
            end
        endcase
        r.position = 6'(run_index);
        return r;
    endfunction

    task automatic flag_error(string what);
        error_count++;
        $display("error at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0h, wanted %0h", name, got, want));
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin : drive_requests
        t_cmd_item req;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_bus.ready) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
                cmd_bus.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                req = pending_requests.pop_front();
                cmd_bus.valid                <= 1'b1;
                cmd_bus.kind                 <= req.kind;
                cmd_bus.command_type         <= req.command_type;
                cmd_bus.table_angle_centideg <= req.angle;
                cmd_bus.screw_depth_tenth_mm <= req.depth;
                cmd_bus.table_at_target      <= req.table_at;
                cmd_bus.screw_at_target      <= req.screw_at;
                cmd_bus.now_ms               <= req.now_ms;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 19);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // expected status of each accepted request
    always @(posedge i_clk) begin : predict_requests
        t_cmd_item seen;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            seen = '{cmd_bus.kind, cmd_bus.command_type, cmd_bus.table_angle_centideg,
                     cmd_bus.screw_depth_tenth_mm, cmd_bus.table_at_target,
                     cmd_bus.screw_at_target, cmd_bus.now_ms};
            status_expected.push_back(predict_status(seen));
        end
    end

    // receiver stalls: always ready, random, sparse periodic, or alternating ready and stalled blocks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            stall_tick = stall_tick + 1;
            if (stall_tick[7:0] == 8'd0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       res_bus.ready <= 1'b1;
                1:       res_bus.ready <= ($urandom_range(0, 3) != 0);
                2:       res_bus.ready <= (stall_tick[1:0] == 2'b00);
                default: res_bus.ready <= !stall_tick[3];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_status want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (status_expected.size() == 0) begin
                flag_error("status arrived with no request outstanding");
            end else begin
                want = status_expected.pop_front();
                check_field("table_target_steps", 32'(res_bus.table_target_steps),
                            32'(want.table_target));
                check_field("table_issue", 32'(res_bus.table_issue),
                            32'(want.table_issue));
                check_field("screw_target_steps",
                            32'($unsigned(res_bus.screw_target_steps)),
                            32'(want.screw_target));
                check_field("screw_issue", 32'(res_bus.screw_issue),
                            32'(want.screw_issue));
                check_field("gripper_command", 32'(res_bus.gripper_command),
                            32'(want.gripper));
                check_field("sequence_done", 32'(res_bus.sequence_done), 32'(want.done));
                check_field("command_position", 32'(res_bus.command_position),
                            32'(want.position));
                check_field("load_rejected", 32'(res_bus.load_rejected),
                            32'(want.rejected));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] kind, logic [2:0] ctype, logic [15:0] angle,
                             logic [10:0] depth, logic tat, logic sat, logic [31:0] nowv);
        pending_requests.push_back('{kind, ctype, angle, depth, tat, sat, nowv});
        items_sent++;
    endtask

    task automatic append_random_command();
        logic [2:0]  ctype;
        logic [15:0] angle;
        if ($urandom_range(0, 15) == 0)
            ctype = 3'($urandom_range(TYPE_SPARE_A, TYPE_SPARE_B));
        else
            ctype = 3'($urandom_range(TYPE_TABLE, TYPE_OPEN));
        angle = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 36000));
        push_item(KIND_APPEND, ctype, angle, 11'($urandom), 1'($urandom), 1'($urandom),
                  clock_ms);
    endtask

    task automatic poll_step();
        // occasional long jumps so gripper commands get past their settle time
        if ($urandom_range(0, 2) == 0)
            clock_ms += $urandom_range(0, cfg_settle + cfg_settle / 2 + 2);
        else
            clock_ms += $urandom_range(0, 3);
        push_item(KIND_POLL, 3'($urandom), 16'($urandom), 11'($urandom),
                  $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, clock_ms);
    endtask

    task automatic run_sequence();
        int n;
        int polls;
        if ($urandom_range(0, 7) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        if ($urandom_range(0, 5) != 0)
            push_item(KIND_CLEAR, 3'($urandom), 16'($urandom), 11'($urandom),
                      1'($urandom), 1'($urandom), clock_ms);
        // mostly short lists, now and then one near or past capacity
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_COMMANDS - 2, MAX_COMMANDS + 3)
                                        : $urandom_range(1, 6);
        repeat (n) append_random_command();
        polls = n * 4 + $urandom_range(0, 6);
        repeat (polls) begin
            case ($urandom_range(0, 19))
                0: push_item(2'($urandom), 3'($urandom), 16'($urandom), 11'($urandom),
                             1'($urandom), 1'($urandom), $urandom);
                1: push_item(KIND_IDLE, 3'($urandom), 16'($urandom), 11'($urandom),
                             1'($urandom), 1'($urandom), clock_ms);
                2: append_random_command();
                default: poll_step();
            endcase
        end
    endtask

    task automatic random_phase(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            run_sequence();
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || cmd_bus.valid || status_expected.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SETTLE:     cfg_settle     = data[15:0];
            CFG_TABLE_GAIN: cfg_table_gain = data[19:0];
            CFG_SCREW_GAIN: cfg_screw_gain = data[23:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [15:0] settle, logic [19:0] tgain, logic [23:0] sgain);
        wait_idle();
        write_reg(CFG_SETTLE, CFG_DATA_W'(settle));
        write_reg(CFG_TABLE_GAIN, CFG_DATA_W'(tgain));
        write_reg(CFG_SCREW_GAIN, sgain);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_SETTLE;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.kind         = KIND_IDLE;
        cmd_bus.command_type = TYPE_TABLE;
        cmd_bus.table_angle_centideg = '0;
        cmd_bus.screw_depth_tenth_mm = '0;
        cmd_bus.table_at_target      = 1'b0;
        cmd_bus.screw_at_target      = 1'b0;
        cmd_bus.now_ms               = '0;
        res_bus.ready        = 1'b0;
        list_count     = 0;
        run_index      = 0;
        run_started    = 1'b0;
        settle_start   = '0;
        cfg_settle     = SETTLE_RESET;
        cfg_table_gain = TABLE_GAIN_RESET;
        cfg_screw_gain = SCREW_GAIN_RESET;
        error_count    = 0;
        items_sent     = 0;
        burst_left     = 0;
        gap_left       = 0;
        quiet_cycles   = 0;
        stall_mode     = 0;
        stall_tick     = '0;
        clock_ms       = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default gains: empty list, idle status, then a table, a screw, a gripper and a spare step
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, 32'd0);
        push_item(KIND_IDLE, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd0);
        push_item(KIND_CLEAR, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd0);
        push_item(KIND_APPEND, TYPE_TABLE, 16'd36000, 11'd0, 1'b0, 1'b0, 32'd0);
        push_item(KIND_APPEND, TYPE_SCREW, 16'd0, 11'd2047, 1'b0, 1'b0, 32'd0);
        push_item(KIND_APPEND, TYPE_GRAB, 16'hFFFF, 11'h7FF, 1'b0, 1'b0, 32'd0);
        push_item(KIND_APPEND, TYPE_SPARE_B, 16'd1234, 11'd99, 1'b0, 1'b0, 32'd0);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, 32'd10);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b0, 32'd20);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, 32'd30);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b1, 32'd40);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd100);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd999);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd1000);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, 32'd1001);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, 32'd1002);
        clock_ms = 32'd2000;
        random_phase(300);

        // widest gains saturate both targets; zero settle ends a gripper on issue
        set_registers(16'd0, 20'hFFFFF, 24'hFFFFFF);
        push_item(KIND_CLEAR, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        push_item(KIND_APPEND, TYPE_BOTH, 16'hFFFF, 11'h7FF, 1'b0, 1'b0, clock_ms);
        push_item(KIND_APPEND, TYPE_LOOSEN, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        push_item(KIND_APPEND, TYPE_OPEN, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, clock_ms);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b1, 1'b1, clock_ms);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        push_item(KIND_POLL, TYPE_TABLE, 16'd0, 11'd0, 1'b0, 1'b0, clock_ms);
        random_phase(300);

        set_registers(16'hFFFF, 20'd0, 24'd0);
        random_phase(300);

        repeat (3) begin
            set_registers(16'($urandom_range(0, 2000)), 20'($urandom),
                          24'($urandom) >> $urandom_range(0, 12));
            random_phase(300);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
